[src/rv64ie_pkg.sv]
// rv64ie_pkg: opcodes, trap and memory-request codes, and the item types for the
// rv64 integer execute stage. no dependencies; used by rv64ie_alu and rv64_integer_execute.

package rv64ie_pkg;

    // major opcodes
    localparam logic [6:0] OPC_LUI     = 7'h37;
    localparam logic [6:0] OPC_AUIPC   = 7'h17;
    localparam logic [6:0] OPC_JAL     = 7'h6F;
    localparam logic [6:0] OPC_JALR    = 7'h67;
    localparam logic [6:0] OPC_BRANCH  = 7'h63;
    localparam logic [6:0] OPC_LOAD    = 7'h03;
    localparam logic [6:0] OPC_STORE   = 7'h23;
    localparam logic [6:0] OPC_OP_IMM  = 7'h13;
    localparam logic [6:0] OPC_OP_IMM32 = 7'h1B;
    localparam logic [6:0] OPC_OP      = 7'h33;
    localparam logic [6:0] OPC_OP32    = 7'h3B;
    localparam logic [6:0] OPC_LOAD_FP = 7'h07;
    localparam logic [6:0] OPC_STORE_FP = 7'h27;
    localparam logic [6:0] OPC_OP_FP   = 7'h53;
    localparam logic [6:0] OPC_SYSTEM  = 7'h73;

    // funct3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_PRIV = 3'd0;
    localparam logic [2:0] F3_SYS_RSVD = 3'd4;

    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [5:0] F6_BASE = 6'h00;
    localparam logic [5:0] F6_ALT  = 6'h10;

    // system immediates
    localparam logic [11:0] IMM_ECALL  = 12'h000;
    localparam logic [11:0] IMM_EBREAK = 12'h001;

    // trap codes
    localparam logic [2:0] TRAP_NONE     = 3'd0;
    localparam logic [2:0] TRAP_RSVD_ENC = 3'd1;
    localparam logic [2:0] TRAP_ENV_CALL = 3'd2;
    localparam logic [2:0] TRAP_BRKPT    = 3'd3;
    localparam logic [2:0] TRAP_NOT_HANDLED = 3'd4;

    // memory request kinds
    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    typedef struct packed {
        logic [31:0] instruction;
        logic [63:0] pc;
        logic [63:0] src1_value;
        logic [63:0] src2_value;
    } t_ex_in;

    typedef struct packed {
        logic [2:0]  trap_code;
        logic        reg_write;
        logic [4:0]  dest_index;
        logic [63:0] dest_value;
        logic [63:0] next_pc;
        logic [1:0]  mem_kind;
        logic [63:0] mem_address;
        logic [1:0]  mem_size_log2;
        logic        load_signed;
        logic [63:0] store_data;
    } t_ex_out;

endpackage

[src/rv64ie_alu.sv]
// rv64ie_alu: combinational decode and execute of one rv64i instruction.
// depends on rv64ie_pkg for opcodes, codes and the t_ex_in / t_ex_out types.

module rv64ie_alu (
    input  rv64ie_pkg::t_ex_in  i_item,
    output rv64ie_pkg::t_ex_out o_result
);

    logic [31:0] ins;
    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  rs1;
    logic [6:0]  f7;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] pc;

    logic [63:0] imm_i;
    logic [63:0] imm_s;
    logic [63:0] imm_b;
    logic [63:0] imm_u;
    logic [63:0] imm_j;

    logic [63:0] opb;
    logic [5:0]  shamt;
    logic [63:0] sum;
    logic [63:0] diff;
    logic        lt_s;
    logic        lt_u;
    logic        eq;
    logic [63:0] sll64;
    logic [63:0] srl64;
    logic [63:0] sra64;
    logic [31:0] sllw;
    logic [31:0] srlw;
    logic [31:0] sraw;
    logic [63:0] agu;
    logic [63:0] pc_plus4;
    logic [63:0] pc_branch;
    logic [63:0] pc_jal;
    logic [63:0] pc_auipc;

    // field split
    assign ins = i_item.instruction;
    assign opc = ins[6:0];
    assign rd  = ins[11:7];
    assign f3  = ins[14:12];
    assign rs1 = ins[19:15];
    assign f7  = ins[31:25];
    assign a   = i_item.src1_value;
    assign b   = i_item.src2_value;
    assign pc  = i_item.pc;

    // immediates
    assign imm_i = {{52{ins[31]}}, ins[31:20]};
    assign imm_s = {{52{ins[31]}}, ins[31:25], ins[11:7]};
    assign imm_b = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    assign imm_u = {{32{ins[31]}}, ins[31:12], 12'b0};
    assign imm_j = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};

    // shared operand: immediate for op-imm forms, rs2 otherwise
    assign opb   = (opc == rv64ie_pkg::OPC_OP_IMM || opc == rv64ie_pkg::OPC_OP_IMM32)
                   ? imm_i : b;
    assign shamt = opb[5:0];

    // arithmetic, compare and shift units
    assign sum   = a + opb;
    assign diff  = a - opb;
    assign lt_s  = $signed(a) < $signed(opb);
    assign lt_u  = a < opb;
    assign eq    = (a == opb);
    assign sll64 = a << shamt;
    assign srl64 = a >> shamt;
    assign sra64 = $signed(a) >>> shamt;
    assign sllw  = a[31:0] << shamt[4:0];
    assign srlw  = a[31:0] >> shamt[4:0];
    assign sraw  = $signed(a[31:0]) >>> shamt[4:0];

    // address and pc adders
    assign agu       = a + ((opc == rv64ie_pkg::OPC_STORE) ? imm_s : imm_i);
    assign pc_plus4  = pc + 64'd4;
    assign pc_branch = pc + imm_b;
    assign pc_jal    = pc + imm_j;
    assign pc_auipc  = pc + imm_u;

    // decode and result select
    always_comb begin
        logic [2:0]  trap;
        logic        wr;
        logic        taken;
        logic [63:0] val;
        logic [63:0] npc;
        logic [1:0]  kind;
        logic [63:0] addr;
        logic [1:0]  size;
        logic        lsg;
        logic [63:0] sdata;

        trap  = rv64ie_pkg::TRAP_NONE;
        wr    = 1'b0;
        taken = 1'b0;
        val   = '0;
        npc   = pc_plus4;
        kind  = rv64ie_pkg::MEM_NONE;
        addr  = '0;
        size  = 2'd0;
        lsg   = 1'b0;
        sdata = '0;

        case (opc)
            rv64ie_pkg::OPC_LUI: begin
                wr  = 1'b1;
                val = imm_u;
            end
            rv64ie_pkg::OPC_AUIPC: begin
                wr  = 1'b1;
                val = pc_auipc;
            end
            rv64ie_pkg::OPC_JAL: begin
                wr  = 1'b1;
                val = pc_plus4;
                npc = pc_jal;
            end
            rv64ie_pkg::OPC_JALR: begin
                if (f3 != 3'd0) begin
                    trap = rv64ie_pkg::TRAP_RSVD_ENC;
                end else begin
                    wr  = 1'b1;
                    val = pc_plus4;
                    npc = {agu[63:1], 1'b0};
                end
            end
            rv64ie_pkg::OPC_BRANCH: begin
                case (f3)
                    rv64ie_pkg::F3_BEQ:  taken = eq;
                    rv64ie_pkg::F3_BNE:  taken = !eq;
                    rv64ie_pkg::F3_BLT:  taken = lt_s;
                    rv64ie_pkg::F3_BGE:  taken = !lt_s;
                    rv64ie_pkg::F3_BLTU: taken = lt_u;
                    rv64ie_pkg::F3_BGEU: taken = !lt_u;
                    default:             trap  = rv64ie_pkg::TRAP_RSVD_ENC;
                endcase
                if (taken) begin
                    npc = pc_branch;
                end
            end
            rv64ie_pkg::OPC_LOAD: begin
                if (f3 == 3'd7) begin
                    trap = rv64ie_pkg::TRAP_RSVD_ENC;
                end else begin
                    kind = rv64ie_pkg::MEM_LOAD;
                    addr = agu;
                    size = f3[1:0];
                    lsg  = !f3[2];
                end
            end
            rv64ie_pkg::OPC_STORE: begin
                if (f3[2]) begin
                    trap = rv64ie_pkg::TRAP_RSVD_ENC;
                end else begin
                    kind  = rv64ie_pkg::MEM_STORE;
                    addr  = agu;
                    size  = f3[1:0];
                    sdata = b;
                end
            end
            rv64ie_pkg::OPC_OP_IMM: begin
                wr = 1'b1;
                case (f3)
                    rv64ie_pkg::F3_ADD:  val = sum;
                    rv64ie_pkg::F3_SLL: begin
                        if (ins[31:26] != rv64ie_pkg::F6_BASE) begin
                            trap = rv64ie_pkg::TRAP_RSVD_ENC;
                        end else begin
                            val = sll64;
                        end
                    end
                    rv64ie_pkg::F3_SLT:  val = {63'd0, lt_s};
                    rv64ie_pkg::F3_SLTU: val = {63'd0, lt_u};
                    rv64ie_pkg::F3_XOR:  val = a ^ opb;
                    rv64ie_pkg::F3_SR: begin
                        if (ins[31:26] == rv64ie_pkg::F6_BASE) begin
                            val = srl64;
                        end else if (ins[31:26] == rv64ie_pkg::F6_ALT) begin
                            val = sra64;
                        end else begin
                            trap = rv64ie_pkg::TRAP_RSVD_ENC;
                        end
                    end
                    rv64ie_pkg::F3_OR:   val = a | opb;
                    default:             val = a & opb;
                endcase
            end
            rv64ie_pkg::OPC_OP_IMM32: begin
                wr = 1'b1;
                if (f3 == rv64ie_pkg::F3_ADD) begin
                    val = {{32{sum[31]}}, sum[31:0]};
                end else if (f3 == rv64ie_pkg::F3_SLL && f7 == rv64ie_pkg::F7_BASE) begin
                    val = {{32{sllw[31]}}, sllw};
                end else if (f3 == rv64ie_pkg::F3_SR && f7 == rv64ie_pkg::F7_BASE) begin
                    val = {{32{srlw[31]}}, srlw};
                end else if (f3 == rv64ie_pkg::F3_SR && f7 == rv64ie_pkg::F7_ALT) begin
                    val = {{32{sraw[31]}}, sraw};
                end else begin
                    trap = rv64ie_pkg::TRAP_RSVD_ENC;
                end
            end
            rv64ie_pkg::OPC_OP: begin
                wr = 1'b1;
                if (f7 == rv64ie_pkg::F7_BASE) begin
                    case (f3)
                        rv64ie_pkg::F3_ADD:  val = sum;
                        rv64ie_pkg::F3_SLL:  val = sll64;
                        rv64ie_pkg::F3_SLT:  val = {63'd0, lt_s};
                        rv64ie_pkg::F3_SLTU: val = {63'd0, lt_u};
                        rv64ie_pkg::F3_XOR:  val = a ^ opb;
                        rv64ie_pkg::F3_SR:   val = srl64;
                        rv64ie_pkg::F3_OR:   val = a | opb;
                        default:             val = a & opb;
                    endcase
                end else if (f7 == rv64ie_pkg::F7_ALT && f3 == rv64ie_pkg::F3_ADD) begin
                    val = diff;
                end else if (f7 == rv64ie_pkg::F7_ALT && f3 == rv64ie_pkg::F3_SR) begin
                    val = sra64;
                end else begin
                    trap = rv64ie_pkg::TRAP_RSVD_ENC;
                end
            end
            rv64ie_pkg::OPC_OP32: begin
                wr = 1'b1;
                if (f7 == rv64ie_pkg::F7_BASE && f3 == rv64ie_pkg::F3_ADD) begin
                    val = {{32{sum[31]}}, sum[31:0]};
                end else if (f7 == rv64ie_pkg::F7_ALT && f3 == rv64ie_pkg::F3_ADD) begin
                    val = {{32{diff[31]}}, diff[31:0]};
                end else if (f7 == rv64ie_pkg::F7_BASE && f3 == rv64ie_pkg::F3_SLL) begin
                    val = {{32{sllw[31]}}, sllw};
                end else if (f7 == rv64ie_pkg::F7_BASE && f3 == rv64ie_pkg::F3_SR) begin
                    val = {{32{srlw[31]}}, srlw};
                end else if (f7 == rv64ie_pkg::F7_ALT && f3 == rv64ie_pkg::F3_SR) begin
                    val = {{32{sraw[31]}}, sraw};
                end else begin
                    trap = rv64ie_pkg::TRAP_RSVD_ENC;
                end
            end
            rv64ie_pkg::OPC_LOAD_FP,
            rv64ie_pkg::OPC_STORE_FP,
            rv64ie_pkg::OPC_OP_FP: begin
                trap = rv64ie_pkg::TRAP_NOT_HANDLED;
            end
            rv64ie_pkg::OPC_SYSTEM: begin
                if (f3 == rv64ie_pkg::F3_PRIV) begin
                    if (rs1 != 5'd0 || rd != 5'd0) begin
                        trap = rv64ie_pkg::TRAP_RSVD_ENC;
                    end else if (ins[31:20] == rv64ie_pkg::IMM_ECALL) begin
                        trap = rv64ie_pkg::TRAP_ENV_CALL;
                    end else if (ins[31:20] == rv64ie_pkg::IMM_EBREAK) begin
                        trap = rv64ie_pkg::TRAP_BRKPT;
                    end else begin
                        trap = rv64ie_pkg::TRAP_RSVD_ENC;
                    end
                end else if (f3 == rv64ie_pkg::F3_SYS_RSVD) begin
                    trap = rv64ie_pkg::TRAP_RSVD_ENC;
                end else begin
                    trap = rv64ie_pkg::TRAP_NOT_HANDLED;
                end
            end
            default: begin
                trap = rv64ie_pkg::TRAP_RSVD_ENC;
            end
        endcase

        // a trap cancels every side effect and holds the pc
        if (trap != rv64ie_pkg::TRAP_NONE) begin
            wr    = 1'b0;
            npc   = pc;
            kind  = rv64ie_pkg::MEM_NONE;
            addr  = '0;
            size  = 2'd0;
            lsg   = 1'b0;
            sdata = '0;
        end

        // x0 is never written
        if (!wr || rd == 5'd0) begin
            wr  = 1'b0;
            val = '0;
        end

        o_result.trap_code     = trap;
        o_result.reg_write     = wr;
        o_result.dest_index    = rd;
        o_result.dest_value    = val;
        o_result.next_pc       = npc;
        o_result.mem_kind      = kind;
        o_result.mem_address   = addr;
        o_result.mem_size_log2 = size;
        o_result.load_signed   = lsg;
        o_result.store_data    = sdata;
    end

endmodule

[src/rv64_integer_execute.sv]
// rv64_integer_execute: top level of the rv64i execute stage, input and result registers.
// depends on rv64ie_pkg and rv64ie_alu.
//
// channel   direction  beat contents
// s_axis    in         instruction, pc, src1_value, src2_value
// m_axis    out        trap, rd write, next pc and memory request of one instruction
//
// one beat per cycle sustained while the output is not stalled.
// an accepted input beat passes the input register, the execute logic and the result register.
// synchronous active-low reset empties both registers; payloads are not reset.
// a stalled output holds the result; the input register keeps filling until both are full.

module rv64_integer_execute (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // instruction[31:0], pc[95:32], src1_value[159:96], src2_value[223:160]
    input  logic [223:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // trap_code[2:0], reg_write[3], dest_index[8:4], dest_value[72:9], next_pc[136:73],
    // mem_kind[138:137], mem_address[202:139], mem_size_log2[204:203],
    // load_signed[205], store_data[269:206], zero pad[271:270]
    output logic [271:0] m_axis_tdata
);

    rv64ie_pkg::t_ex_in  r_in;
    rv64ie_pkg::t_ex_in  n_in;
    logic                r_in_valid;
    rv64ie_pkg::t_ex_out r_out;
    rv64ie_pkg::t_ex_out exec_result;
    logic                r_out_valid;
    logic                out_ready;
    logic                in_ready;

    // stage handshakes
    assign out_ready     = !r_out_valid || m_axis_tready;
    assign in_ready      = !r_in_valid || out_ready;
    assign s_axis_tready = in_ready;

    // unpack the input beat
    assign n_in.instruction = s_axis_tdata[31:0];
    assign n_in.pc          = s_axis_tdata[95:32];
    assign n_in.src1_value  = s_axis_tdata[159:96];
    assign n_in.src2_value  = s_axis_tdata[223:160];

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (in_ready && s_axis_tvalid) begin
            r_in <= n_in;
        end
    end

    rv64ie_alu u_alu (
        .i_item   (r_in),
        .o_result (exec_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
        if (out_ready && r_in_valid) begin
            r_out <= exec_result;
        end
    end

    // pack the result beat
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00,
                            r_out.store_data,
                            r_out.load_signed,
                            r_out.mem_size_log2,
                            r_out.mem_address,
                            r_out.mem_kind,
                            r_out.next_pc,
                            r_out.dest_value,
                            r_out.dest_index,
                            r_out.reg_write,
                            r_out.trap_code};

    // a trapped instruction never writes a register or touches memory
    a_trap_no_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.trap_code != rv64ie_pkg::TRAP_NONE)
        |-> (!r_out.reg_write && r_out.mem_kind == rv64ie_pkg::MEM_NONE))
        else $error("trapped instruction has side effects");

    // x0 is never a write destination
    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.reg_write) |-> (r_out.dest_index != 5'd0))
        else $error("write to x0");

    // an item in the input register moves to the result register when it has room
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_ready) |=> r_out_valid)
        else $error("item lost between stages");

    // both stages full and output stalled blocks the input
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while pipeline full");

    // no memory request means zero address and data
    a_mem_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.mem_kind == rv64ie_pkg::MEM_NONE)
        |-> (r_out.mem_address == 64'd0 && r_out.store_data == 64'd0))
        else $error("memory fields set without a request");

endmodule
